// ----- rtl/core/bft_pkg.sv -----
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types and constants of the batched transaction FIFO.
// ----------------------------------------------------------------------------
package bft_pkg;

	// defaults for the top-level parameters
	localparam int TRANS_DEPTH_DEF = 16;
	localparam int ACTIONS_MAX_DEF = 16;

	// actions_per_transaction register
	localparam int          CFG_W      = 5;
	localparam logic [4:0]  APT_RESET  = 5'd16;
	localparam int          PADDR_W    = 3;
	localparam int          PDATA_W    = 32;

	typedef enum logic [0:0] {
		REG_APT = 1'b0
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_PUBLISH = 2'd1,
		CMD_REMOVE  = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_FULL    = 3'd1,
		STS_FILLED  = 3'd2,
		STS_EMPTY   = 3'd3,
		STS_DRAINED = 3'd4,
		STS_NOTHING = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_READ = 2'b10
	} fsm_t;

endpackage

// ----- rtl/core/bft_ram.sv -----
// ----------------------------------------------------------------------------
// bft_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bft_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/batched_transaction_fifo.sv -----
// ----------------------------------------------------------------------------
// batched_transaction_fifo
// Single-producer, single-consumer queue of transactions of action words.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group: s_tuser carries the command (insert,
// publish, remove), s_tdata the 64-bit word to insert. Each request yields
// exactly one result on the m_ group: m_tuser the status, m_tdata the word
// taken by a remove (zero otherwise).
// Insert and publish results are registered in the cycle after the request
// is taken, and such requests can be taken every cycle while the receiver
// keeps up. A remove from a nonempty queue reads the word and the slot
// length from the two RAMs; its result is registered from FSM_READ, in
// which no request is taken. An empty-queue remove is answered like an insert.
// Words live in a TRANS_DEPTH*ACTIONS_MAX deep RAM, slot lengths in a
// TRANS_DEPTH deep RAM; a slot length is read only once it has been written.
// A request is taken only while the output register is empty or being
// emptied, so a stalled receiver holds off new requests after one result.
// Reset empties the queue, clears the output register and sets
// actions_per_transaction to 16; no RAM clearing pass is needed. APB
// addresses 0-3 write it; the user must do so only while idle (unguarded).
// ----------------------------------------------------------------------------
module batched_transaction_fifo
	import bft_pkg::*;
#(
	parameter int TRANS_DEPTH = TRANS_DEPTH_DEF,
	parameter int ACTIONS_MAX = ACTIONS_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// request stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,   // [63:0] data_in
	input  logic [1:0]         s_tuser,   // [1:0] cmd
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,   // [63:0] data_out
	output logic [2:0]         m_tuser    // [2:0] status
);

	localparam int SLOT_W = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
	localparam int POS_W  = (ACTIONS_MAX > 1) ? $clog2(ACTIONS_MAX) : 1;
	localparam int CNT_W  = $clog2(ACTIONS_MAX + 1);
	localparam int PUB_W  = $clog2(TRANS_DEPTH + 1);
	localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int ADEPTH = TRANS_DEPTH * ACTIONS_MAX;
	localparam int ADDR_W = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;

	fsm_t               state_q;
	logic [CFG_W-1:0]   apt_q;
	logic [SLOT_W-1:0]  head_q, tail_q;
	logic [PUB_W-1:0]   pub_cnt_q;
	logic [CNT_W-1:0]   fill_q, read_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [63:0]        out_data_q;

	logic               take;
	cmd_t               cmd;
	logic [LIM_W-1:0]   apt_ext, limit;
	logic [CNT_W-1:0]   fill_inc, read_inc;
	logic               queue_full, close_now, drain_now;
	logic [SLOT_W-1:0]  tail_next, head_next;
	logic               result_set;

	logic               act_we;
	logic [ADDR_W-1:0]  act_waddr, act_raddr;
	logic [63:0]        act_rdata;
	logic               len_we;
	logic [CNT_W-1:0]   len_wdata, len_rdata;

	// configuration
	assign pready = 1'b1;
	assign prdata = PDATA_W'(apt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apt_q <= APT_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_idx_t'(paddr[PADDR_W-1]) == REG_APT) begin
			apt_q <= pwdata[CFG_W-1:0];
		end
	end

	// effective length: zero acts as one, clamp at ACTIONS_MAX
	assign apt_ext = LIM_W'(apt_q);
	always_comb begin
		if (apt_ext == '0) begin
			limit = LIM_W'(1);
		end else if (apt_ext > LIM_W'(ACTIONS_MAX)) begin
			limit = LIM_W'(ACTIONS_MAX);
		end else begin
			limit = apt_ext;
		end
	end

	assign s_tready = (state_q == FSM_IDLE) && (!out_valid_q || m_tready);
	assign take     = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);

	assign fill_inc   = fill_q + CNT_W'(1);
	assign read_inc   = read_q + CNT_W'(1);
	assign queue_full = (fill_q == '0) && (pub_cnt_q == PUB_W'(TRANS_DEPTH));
	assign close_now  = LIM_W'(fill_inc) >= limit;
	assign drain_now  = read_inc >= len_rdata;
	assign tail_next  = (tail_q == SLOT_W'(TRANS_DEPTH - 1)) ? '0 : tail_q + SLOT_W'(1);
	assign head_next  = (head_q == SLOT_W'(TRANS_DEPTH - 1)) ? '0 : head_q + SLOT_W'(1);

	// load a result for every taken request except a remove that waits on the RAMs
	assign result_set = (state_q == FSM_READ)
		|| (take && !(cmd == CMD_REMOVE && pub_cnt_q != '0));

	// RAM ports
	assign act_we    = take && cmd == CMD_INSERT && !queue_full;
	assign act_waddr = ADDR_W'(tail_q) * ADDR_W'(ACTIONS_MAX) + ADDR_W'(fill_q[POS_W-1:0]);
	assign act_raddr = ADDR_W'(head_q) * ADDR_W'(ACTIONS_MAX) + ADDR_W'(read_q[POS_W-1:0]);
	assign len_we    = (act_we && close_now)
		|| (take && cmd == CMD_PUBLISH && fill_q != '0);
	assign len_wdata = (cmd == CMD_INSERT) ? fill_inc : fill_q;

	bft_ram #(.WIDTH(64), .DEPTH(ADEPTH)) u_action_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (s_tdata),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	bft_ram #(.WIDTH(CNT_W), .DEPTH(TRANS_DEPTH)) u_length_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (tail_q),
		.wdata (len_wdata),
		.raddr (head_q),
		.rdata (len_rdata)
	);

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			pub_cnt_q   <= '0;
			fill_q      <= '0;
			read_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_set) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (take) begin
						case (cmd)
							CMD_INSERT: begin
								if (!queue_full) begin
									if (close_now) begin
										fill_q    <= '0;
										tail_q    <= tail_next;
										pub_cnt_q <= pub_cnt_q + PUB_W'(1);
									end else begin
										fill_q <= fill_inc;
									end
								end
							end
							CMD_PUBLISH: begin
								if (fill_q != '0) begin
									fill_q    <= '0;
									tail_q    <= tail_next;
									pub_cnt_q <= pub_cnt_q + PUB_W'(1);
								end
							end
							CMD_REMOVE: begin
								// wait in FSM_READ for the RAM read unless empty
								if (pub_cnt_q != '0) begin
									state_q <= FSM_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				FSM_READ: begin
					state_q <= FSM_IDLE;
					if (drain_now) begin
						read_q    <= '0;
						head_q    <= head_next;
						pub_cnt_q <= pub_cnt_q - PUB_W'(1);
					end else begin
						read_q <= read_inc;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == FSM_READ) begin
			out_data_q   <= act_rdata;
			out_status_q <= drain_now ? STS_DRAINED : STS_OK;
		end else if (take) begin
			out_data_q <= '0;
			case (cmd)
				CMD_INSERT: begin
					if (queue_full) begin
						out_status_q <= STS_FULL;
					end else if (close_now) begin
						out_status_q <= STS_FILLED;
					end else begin
						out_status_q <= STS_OK;
					end
				end
				CMD_PUBLISH: out_status_q <= (fill_q == '0) ? STS_NOTHING : STS_OK;
				CMD_REMOVE:  out_status_q <= STS_EMPTY;
				default:     out_status_q <= STS_OK;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// checks
	a_pub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pub_cnt_q <= PUB_W'(TRANS_DEPTH))
		else $error("published count above slot count");

	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_READ |=> state_q == FSM_IDLE && out_valid_q)
		else $error("remove read did not produce a result");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_READ |-> pub_cnt_q != '0 && !s_tready)
		else $error("remove read on empty queue or while taking requests");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(ACTIONS_MAX))
		else $error("open transaction overran its slot");

endmodule

// ----- tb/batched_transaction_fifo_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// batched_transaction_fifo_tb
// Self-checking bench for the batched transaction FIFO. A directed part covers
// an empty queue, publishing with nothing open, the unused command, extreme
// words, a shortened length mid-transaction and a full queue. Random phases
// then follow under several transaction lengths, with random stalls on both
// streams. A scoreboard predicts every status and word.
// ----------------------------------------------------------------------------
module batched_transaction_fifo_tb;
	import bft_pkg::*;

	localparam int SLOTS         = TRANS_DEPTH_DEF;
	localparam int WORDS         = ACTIONS_MAX_DEF;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 75;
	localparam int MAX_REPORTS   = 100;

	localparam logic [PADDR_W-1:0] APT_ADDR    = {REG_APT, 2'b00};
	localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;

	typedef enum int {
		MIX_BALANCED = 0,
		MIX_PRODUCER = 1,
		MIX_CONSUMER = 2
	} mix_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] word;
	} result_t;

	class bft_scoreboard;
		result_t     pending_results[$];
		logic [63:0] words[SLOTS*WORDS];
		int          lengths[SLOTS];
		int          head, tail, published, fill, rd;
		logic [4:0]  apt_reg;
		int          n_requests, n_results, n_errors, n_full, n_drained;

		function new();
			foreach (lengths[i]) lengths[i] = 0;
			head = 0; tail = 0; published = 0; fill = 0; rd = 0;
			apt_reg = APT_RESET;
			n_requests = 0; n_results = 0; n_errors = 0; n_full = 0; n_drained = 0;
		endfunction

		function void set_apt(logic [4:0] value);
			apt_reg = value;
		endfunction

		// out-of-range lengths clamp to 1..WORDS
		function int limit();
			int n;
			n = apt_reg;
			if (n < 1) n = 1;
			if (n > WORDS) n = WORDS;
			return n;
		endfunction

		function void close_open();
			lengths[tail] = fill;
			tail = (tail + 1 >= SLOTS) ? 0 : tail + 1;
			published++;
			fill = 0;
		endfunction

		function void take_request(cmd_t cmd, logic [63:0] word);
			result_t r;
			r.status = STS_OK;
			r.word   = '0;
			case (cmd)
				CMD_INSERT: begin
					if (fill == 0 && published >= SLOTS) begin
						r.status = STS_FULL;
					end else begin
						words[tail*WORDS + (fill % WORDS)] = word;
						fill++;
						if (fill >= limit()) begin
							close_open();
							r.status = STS_FILLED;
						end
					end
				end
				CMD_PUBLISH: begin
					if (fill == 0) r.status = STS_NOTHING;
					else close_open();
				end
				CMD_REMOVE: begin
					if (published == 0) begin
						r.status = STS_EMPTY;
					end else begin
						r.word = words[head*WORDS + (rd % WORDS)];
						rd++;
						if (rd >= lengths[head]) begin
							rd = 0;
							head = (head + 1 >= SLOTS) ? 0 : head + 1;
							published--;
							r.status = STS_DRAINED;
						end
					end
				end
				default: ;
			endcase
			if (r.status == STS_FULL) n_full++;
			if (r.status == STS_DRAINED) n_drained++;
			n_requests++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [2:0] status, logic [63:0] word);
			result_t e;
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual status %0d data %h",
						$time, status, word);
				return;
			end
			e = pending_results.pop_front();
			if (status !== e.status) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
			end
			if (word !== e.word) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: data expected %h actual %h", $time, e.word, word);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;   // [63:0] data_in
	logic [1:0]         s_tuser;   // [1:0] cmd
	logic               m_tvalid;
	logic               m_tready;
	logic [63:0]        m_tdata;   // [63:0] data_out
	logic [2:0]         m_tuser;   // [2:0] status

	bft_scoreboard sb;
	bit            gaps_on;
	int            cycles;
	int            n_settings;

	batched_transaction_fifo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("batched_transaction_fifo: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// result side: random stall bursts while gaps are on
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (burst) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_request(input cmd_t cmd, input logic [63:0] word);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sb.take_request(cmd, word);
	endtask

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_request(input mix_t mix);
		int   r;
		int   ins_top, rem_top, pub_top;
		cmd_t cmd;
		case (mix)
			MIX_PRODUCER: begin ins_top = 60; rem_top = 85; pub_top = 95; end
			MIX_CONSUMER: begin ins_top = 25; rem_top = 85; pub_top = 95; end
			default:      begin ins_top = 45; rem_top = 85; pub_top = 95; end
		endcase
		r = $urandom_range(0, 99);
		if (r < ins_top) cmd = CMD_INSERT;
		else if (r < rem_top) cmd = CMD_REMOVE;
		else if (r < pub_top) cmd = CMD_PUBLISH;
		else cmd = CMD_NOP;
		send_request(cmd, random_word());
	endtask

	// drop valid and wait out every outstanding result plus the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == APT_ADDR) sb.set_apt(value[CFG_W-1:0]);
	endtask

	task automatic apb_check_read();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(PDATA_W-CFG_W){1'b0}}, sb.apt_reg}) begin
			sb.n_errors++;
			$display("%0t: register read expected %h actual %h", $time,
				{{(PDATA_W-CFG_W){1'b0}}, sb.apt_reg}, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// upper data bits are random: the register keeps only its five bits
	task automatic configure(input logic [4:0] value);
		settle();
		apb_write(APT_ADDR, {$urandom_range(0, 1) ? $urandom : 32'd0} & ~32'h1f | value);
		apb_check_read();
		n_settings++;
	endtask

	initial begin
		logic [4:0] setting;
		clk      = 1'b0;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_NOP;
		m_tready = 1'b0;
		gaps_on  = 1'b1;
		cycles   = 0;
		n_settings = 0;
		sb = new();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, nothing open, unused command, extreme words
		apb_check_read();
		send_request(CMD_REMOVE, '1);
		send_request(CMD_PUBLISH, '0);
		send_request(CMD_NOP, '1);
		send_request(CMD_INSERT, '0);
		send_request(CMD_INSERT, '1);
		send_request(CMD_PUBLISH, '1);
		send_request(CMD_REMOVE, '0);
		send_request(CMD_REMOVE, '0);

		// shorten the length while a transaction is open
		repeat (3) send_request(CMD_INSERT, random_word());
		configure(5'd2);
		send_request(CMD_INSERT, random_word());

		// one word per transaction, fill every slot, then overflow
		configure(5'd1);
		repeat (SLOTS) send_request(CMD_INSERT, random_word());

		// a write beyond the register must leave it alone
		settle();
		apb_write(UNUSED_ADDR, $urandom);
		apb_check_read();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       setting = 5'd0;
				1:       setting = 5'd31;
				2:       setting = 5'd16;
				3:       setting = 5'd3;
				4:       setting = 5'd17;
				default: setting = 5'($urandom_range(1, 31));
			endcase
			configure(setting);
			if (p == RANDOM_PHASES - 1) gaps_on = 1'b0;
			repeat (PHASE_ITEMS) random_request(mix_t'(p % 3));
		end

		settle();
		repeat (10) @(posedge clk);
		$display("%0d requests issued, %0d results checked, %0d register settings",
			sb.n_requests, sb.n_results, n_settings);
		$display("%0d queue-full and %0d drained results seen", sb.n_full, sb.n_drained);
		if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
			$display("batched_transaction_fifo: match");
		end else begin
			$display("batched_transaction_fifo: mismatch");
		end
		$finish;
	end

endmodule
